FILE: design/tkbh_pkg.sv
package tkbh_pkg;

  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam logic [31:0] MIX_MUL      = 32'h045d9f3b;
  localparam int          MIX_SHIFT    = 16;
  localparam int          DJB_SHIFT    = 5;
  localparam logic [31:0] CAP_RESET    = 32'd16;
  localparam int          JOB_Q_DEPTH  = 2;
  localparam int          JOB_Q_PTR_W  = $clog2(JOB_Q_DEPTH);
  localparam int          JOB_Q_CNT_W  = $clog2(JOB_Q_DEPTH + 1);
  localparam int          DIV_STEPS    = 32;
  localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FN_STR  = 2'd0,
    FN_WORD = 2'd1,
    FN_CHAR = 2'd2,
    FN_UNK  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_FIN,
    ST_DIV,
    ST_OUT
  } back_state_t;

  // one finished key waiting for the mixer
  typedef struct packed {
    logic        known;
    logic [31:0] key;
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // only the low product word is kept, so a 32x32 multiply is enough
  function automatic logic [31:0] mix_round(input logic [31:0] h);
    logic [31:0] x;
    logic [31:0] p;
    x = h ^ (h >> MIX_SHIFT);
    p = x * MIX_MUL;
    return p;
  endfunction

endpackage

FILE: design/tkbh_front.sv
module tkbh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  tkbh_pkg::q_status_t q_status,
  output logic               push,
  output tkbh_pkg::job_t     push_job
);

  logic [31:0]     acc_r, acc_nxt;
  tkbh_pkg::func_t func;
  logic            accept;
  logic [31:0]     byte_sx;
  logic            byte_nz;

  assign func      = tkbh_pkg::func_t'(in_tuser);
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign byte_sx   = tkbh_pkg::sext8(in_tdata[7:0]);
  assign byte_nz   = (in_tdata[7:0] != 8'd0);

  always_comb begin
    acc_nxt       = acc_r;
    push          = 1'b0;
    push_job.known = 1'b1;
    push_job.key   = in_tdata;
    case (func)
      tkbh_pkg::FN_STR: begin
        push_job.key = acc_r;
        if (accept) begin
          if (byte_nz) begin
            // acc * 33 + signed byte
            acc_nxt = (acc_r << tkbh_pkg::DJB_SHIFT) + acc_r + byte_sx;
          end else begin
            acc_nxt = tkbh_pkg::HASH_SEED;
            push    = 1'b1;
          end
        end
      end
      tkbh_pkg::FN_WORD: begin
        push = accept;
      end
      tkbh_pkg::FN_CHAR: begin
        push_job.key = byte_sx;
        push         = accept;
      end
      default: begin
        push_job.known = 1'b0;
        push_job.key   = '0;
        push           = accept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= tkbh_pkg::HASH_SEED;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

FILE: design/tkbh_queue.sv
module tkbh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tkbh_pkg::job_t      push_job,
  input  logic                pop,
  output tkbh_pkg::job_t      pop_job,
  output tkbh_pkg::q_status_t q_status
);

  tkbh_pkg::job_t                     q_r [tkbh_pkg::JOB_Q_DEPTH];
  logic [tkbh_pkg::JOB_Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tkbh_pkg::JOB_Q_CNT_W-1:0]   cnt_r;

  assign q_status.full  = (cnt_r == tkbh_pkg::JOB_Q_CNT_W'(tkbh_pkg::JOB_Q_DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign pop_job        = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == tkbh_pkg::JOB_Q_PTR_W'(tkbh_pkg::JOB_Q_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == tkbh_pkg::JOB_Q_PTR_W'(tkbh_pkg::JOB_Q_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/tkbh_back.sv
module tkbh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         cap_i,
  input  tkbh_pkg::q_status_t q_status,
  input  tkbh_pkg::job_t      pop_job,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic [0:0]          out_tuser
);

  tkbh_pkg::back_state_t state_r, state_nxt;
  logic [31:0]                  h_r;
  logic [31:0]                  rem_r;
  logic [31:0]                  div_r;
  logic [tkbh_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                         known_r;
  logic                         out_tvalid_r;
  logic [31:0]                  out_tdata_r;
  logic                         out_tuser_r;
  logic                         out_load;
  logic [31:0]                  h_fin;
  logic [32:0]                  rem_sh;
  logic [32:0]                  rem_sub;
  logic [31:0]                  rem_step;

  assign h_fin    = h_r ^ (h_r >> tkbh_pkg::MIX_SHIFT);
  assign rem_sh   = {rem_r, div_r[31]};
  assign rem_sub  = rem_sh - {1'b0, cap_i};
  assign rem_step = rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkbh_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = pop_job.known ? tkbh_pkg::ST_MIX1 : tkbh_pkg::ST_OUT;
        end
      end
      tkbh_pkg::ST_MIX1: state_nxt = tkbh_pkg::ST_MIX2;
      tkbh_pkg::ST_MIX2: state_nxt = tkbh_pkg::ST_FIN;
      tkbh_pkg::ST_FIN:  state_nxt = (cap_i == '0) ? tkbh_pkg::ST_OUT : tkbh_pkg::ST_DIV;
      tkbh_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = tkbh_pkg::ST_OUT;
        end
      end
      tkbh_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = tkbh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tkbh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      tkbh_pkg::ST_IDLE: pop      = !q_status.empty;
      tkbh_pkg::ST_OUT:  out_load = !out_tvalid_r || out_tready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tkbh_pkg::ST_IDLE: begin
        h_r     <= pop_job.key;
        known_r <= pop_job.known;
        rem_r   <= '0;
      end
      tkbh_pkg::ST_MIX1, tkbh_pkg::ST_MIX2: begin
        h_r <= tkbh_pkg::mix_round(h_r);
      end
      tkbh_pkg::ST_FIN: begin
        // zero capacity: the full mixed hash is the bucket
        rem_r <= (cap_i == '0) ? h_fin : '0;
        div_r <= h_fin;
        cnt_r <= tkbh_pkg::DIV_CNT_W'(tkbh_pkg::DIV_STEPS - 1);
      end
      tkbh_pkg::ST_DIV: begin
        rem_r <= rem_step;
        div_r <= div_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
        h_r <= h_r;
      end
    endcase
    if (out_load) begin
      out_tdata_r <= rem_r;
      out_tuser_r <= known_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tkbh_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_div_cap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkbh_pkg::ST_DIV) |-> (cap_i != '0))
    else $error("division running with zero capacity");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("loaded result not presented");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkbh_pkg::ST_OUT && !known_r) |-> (rem_r == '0))
    else $error("unknown key type with nonzero bucket");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == tkbh_pkg::ST_MIX1 || state_r == tkbh_pkg::ST_OUT))
    else $error("request popped without starting work");

endmodule

FILE: design/typed_key_bucket_hash_top.sv
// Typed key bucket hash. String keys stream in one byte per request on func 0 and are
// folded into a registered DJB2 accumulator; a zero byte closes the key. Word, char
// and unknown-type requests each close a key at once. Every closed key goes into a
// two-entry job queue, and the back end runs each known-type key through two
// xor-shift-multiply rounds, a final xor-shift and a one-bit-per-cycle restoring modulo
// by table_capacity. A key goes from queue to output register by pop, two multiply
// rounds, final xor, 32 modulo steps and output load; zero capacity skips the modulo and
// an unknown type skips the mixing and the modulo. The modulo iteration sets the
// sustained rate. Nonzero string bytes are accepted every cycle while the queue has room.
// Write table_capacity (reset 16) only when no key is in flight.
module typed_key_bucket_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_word
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] bucket
  output logic [0:0]  out_tuser,  // [0] type_known
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]         cap_r;
  logic                push;
  logic                pop;
  tkbh_pkg::job_t      push_job;
  tkbh_pkg::job_t      pop_job;
  tkbh_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tkbh_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  tkbh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  tkbh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  tkbh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_i      (cap_r),
    .q_status   (q_status),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/typed_key_bucket_hash_top_test.sv
`timescale 1ns / 100ps

module typed_key_bucket_hash_top_test;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 48;   // longer than a key's trip from queue to output register
  localparam int RANDOM_ITEMS = 620;

  typedef struct {
    logic [31:0] bucket;
    logic        known;
  } bucket_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] key_word
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] bucket
  logic [0:0]  out_tuser;  // [0] type_known
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // predictor state
  logic [31:0] bucket_count;
  logic [31:0] djb_acc;
  bucket_rec_t pending_buckets[$];

  int fail_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  typed_key_bucket_hash_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("typed_key_bucket_hash_top_test NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] key_to_bucket(input logic [31:0] key);
    logic [31:0] h;
    h = key;
    repeat (2) begin
      h = h ^ (h >> 16);
      h = h * tkbh_pkg::MIX_MUL;
    end
    h = h ^ (h >> 16);
    return (bucket_count == 32'd0) ? h : h % bucket_count;
  endfunction

  function automatic logic [31:0] sign_ext_byte(input logic [31:0] w);
    return {{24{w[7]}}, w[7:0]};
  endfunction

  // update string state and queue the expected bucket for one accepted request
  function automatic void track_key(input tkbh_pkg::func_t f, input logic [31:0] w);
    bucket_rec_t r;
    r.known = 1'b1;
    case (f)
      tkbh_pkg::FN_STR: begin
        if (w[7:0] != 8'd0) begin
          djb_acc = (djb_acc << 5) + djb_acc + sign_ext_byte(w);
          return;
        end
        r.bucket = key_to_bucket(djb_acc);
        djb_acc = tkbh_pkg::HASH_SEED;
      end
      tkbh_pkg::FN_WORD: r.bucket = key_to_bucket(w);
      tkbh_pkg::FN_CHAR: r.bucket = key_to_bucket(sign_ext_byte(w));
      default: begin
        r.bucket = 32'd0;
        r.known = 1'b0;
      end
    endcase
    pending_buckets.push_back(r);
  endfunction

  always @(posedge clk) begin : check_results
    bucket_rec_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_buckets.size() == 0) begin
        $error("unexpected result: bucket=%0h type_known=%0b", out_tdata, out_tuser[0]);
        fail_count++;
      end else begin
        exp_r = pending_buckets.pop_front();
        if (out_tdata !== exp_r.bucket) begin
          $error("bucket: expected %0h, got %0h", exp_r.bucket, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== exp_r.known) begin
          $error("type_known: expected %0b, got %0b", exp_r.known, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // receiver: switches among four out_tready patterns
  int rx_cnt = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    rx_cnt++;
    if (rx_cnt % 50 == 0)
      rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_cnt % 5 == 0);
      default: out_tready <= ((rx_cnt % 15) >= 12);
    endcase
  end

  task automatic send_item(input tkbh_pkg::func_t f, input logic [31:0] w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    track_key(f, w);
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_buckets.size() != 0) @(posedge clk);
    // a trailing string byte may still be in flight without any result
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [31:0] cap);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    bucket_count = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_string_byte(input logic [7:0] b);
    send_item(tkbh_pkg::FN_STR, ($urandom() & 32'hffffff00) | {24'd0, b});
  endtask

  task automatic send_random_scalar;
    case ($urandom_range(0, 3))
      0, 1: send_item(tkbh_pkg::FN_WORD, $urandom());
      2: send_item(tkbh_pkg::FN_CHAR, $urandom());
      default: send_item(tkbh_pkg::FN_UNK, $urandom());
    endcase
  endtask

  task automatic test_default_capacity;
    send_item(tkbh_pkg::FN_WORD, 32'h0000_0000);
    send_item(tkbh_pkg::FN_WORD, 32'hffff_ffff);
    send_item(tkbh_pkg::FN_CHAR, 32'h0000_007f);
    send_item(tkbh_pkg::FN_CHAR, 32'habcd_ef80);
    send_item(tkbh_pkg::FN_UNK, 32'h1234_5678);
    send_item(tkbh_pkg::FN_STR, 32'hdead_be00);   // empty string
    send_string_byte(8'h61);
    send_string_byte(8'hff);                      // negative char in string
    send_item(tkbh_pkg::FN_UNK, 32'hffff_ffff);   // must not disturb the partial string
    send_item(tkbh_pkg::FN_WORD, 32'h8000_0001);  // scalar inside a string
    send_item(tkbh_pkg::FN_CHAR, 32'h0000_00ff);
    send_string_byte(8'h80);
    send_item(tkbh_pkg::FN_STR, 32'h0000_0000);
  endtask

  task automatic test_capacity_extremes;
    logic [31:0] caps [4];
    caps = '{32'd1, 32'hffff_ffff, 32'd0, 32'd7};
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      send_item(tkbh_pkg::FN_WORD, $urandom());
      send_string_byte(8'h01);
      send_item(tkbh_pkg::FN_STR, 32'hffff_ff00);
    end
  endtask

  task automatic test_random_keys;
    int phase_end;
    int len;
    int mid;
    int start_count;
    start_count = items_sent;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_capacity($urandom_range(1, 64));
        1: set_capacity($urandom());
        2: set_capacity(32'hffff_ffff);
        3: set_capacity(32'd1 << $urandom_range(0, 31));
        4: set_capacity(32'd0);
        default: set_capacity($urandom_range(1, 1000));
      endcase
      phase_end = start_count + (ph + 1) * RANDOM_ITEMS / 6;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            len = $urandom_range(0, 8);
            repeat (len) send_string_byte(8'($urandom_range(1, 255)));
            send_item(tkbh_pkg::FN_STR, $urandom() & 32'hffffff00);
          end
          5, 6, 7: send_random_scalar();
          8: begin
            // a scalar key interleaved with a string
            len = $urandom_range(1, 6);
            mid = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
              if (i == mid) send_random_scalar();
              send_string_byte(8'($urandom_range(1, 255)));
            end
            send_item(tkbh_pkg::FN_STR, $urandom() & 32'hffffff00);
          end
          default: send_item(tkbh_pkg::func_t'($urandom_range(0, 3)), $urandom());
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    in_tuser = tkbh_pkg::FN_STR;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 32'd0;
    bucket_count = tkbh_pkg::CAP_RESET;
    djb_acc = tkbh_pkg::HASH_SEED;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_capacity();
    test_capacity_extremes();
    test_random_keys();
    drain();

    if (fail_count == 0 && pending_buckets.size() == 0) begin
      $display("typed_key_bucket_hash_top_test OK");
    end else begin
      $display("typed_key_bucket_hash_top_test NOT OK");
    end
    $finish;
  end

endmodule
